// File: rtl/sha256_message_hasher_assert.svh
// Assertion macros for the SHA-256 message hasher.
// Taken in by `include; no other dependencies. Defining ASSERT_OFF empties them.
`ifndef SHA256_MESSAGE_HASHER_ASSERT_SVH
`define SHA256_MESSAGE_HASHER_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define SHA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sha256 hasher: same-cycle check failed");

// next-cycle implication
`define SHA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sha256 hasher: next-cycle check failed");

`else

`define SHA_ASSERT_NOW(label, clk, rst, ante, cons)
`define SHA_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/sha_mh_pkg.sv
// Shared types, constants and bit functions for the SHA-256 message hasher.
// No dependencies; used by sha_mh_sched, sha_mh_core and the top level.
package sha_mh_pkg;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   localparam logic [31:0] INIT_H [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   typedef struct packed {
      logic load;   // copy chaining value into working variables
      logic round;  // one compression round
      logic fold;   // add working variables into chaining value
      logic init;   // back to initial hash words
   } core_ctrl_type;

   typedef struct packed {
      logic push;   // shift one byte into the block window
      logic step;   // advance schedule by one word
   } sched_ctrl_type;

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
   endfunction

endpackage

// File: rtl/sha_mh_sched.sv
// Block window and message schedule: 64-byte shift line that doubles as the
// 16-word schedule window. Depends on sha_mh_pkg.
module sha_mh_sched (
   input  logic                       clock,
   input  sha_mh_pkg::sched_ctrl_type ctrl,
   input  logic [7:0]                 push_byte,
   output logic [31:0]                w_word
);
   import sha_mh_pkg::*;

   logic [511:0] win_ff;
   logic [511:0] win_in;
   logic [31:0]  next_w;

   // word 0 at the top: w[t-16]; word 1: w[t-15]; word 9: w[t-7]; word 14: w[t-2]
   assign next_w = small_sigma1(win_ff[63:32]) + win_ff[223:192]
                 + small_sigma0(win_ff[479:448]) + win_ff[511:480];
   assign w_word = win_ff[511:480];

   always_comb begin
      win_in = win_ff;
      if (ctrl.push) begin
         win_in = {win_ff[503:0], push_byte};
      end else if (ctrl.step) begin
         win_in = {win_ff[479:0], next_w};
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

endmodule

// File: rtl/sha_mh_core.sv
// Compression unit: working variables a..h, one round a cycle, and the
// chaining value with its fold adders. Depends on sha_mh_pkg.
module sha_mh_core (
   input  logic                      clock,
   input  logic                      reset,
   input  sha_mh_pkg::core_ctrl_type ctrl,
   input  logic [31:0]               k_word,
   input  logic [31:0]               w_word,
   input  logic [2:0]                rd_index,
   output logic [31:0]               rd_word
);
   import sha_mh_pkg::*;

   logic [31:0] h_ff [8];
   logic [31:0] h_in [8];
   logic [31:0] v_ff [8];
   logic [31:0] v_in [8];
   logic [31:0] t1;
   logic [31:0] t2;
   logic [31:0] ch;
   logic [31:0] maj;

   assign ch  = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
   assign maj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
   assign t1  = v_ff[7] + big_sigma1(v_ff[4]) + ch + k_word + w_word;
   assign t2  = big_sigma0(v_ff[0]) + maj;

   assign rd_word = h_ff[rd_index];

   always_comb begin
      v_in = v_ff;
      h_in = h_ff;
      if (ctrl.load) begin
         v_in = h_ff;
      end else if (ctrl.round) begin
         v_in[7] = v_ff[6];
         v_in[6] = v_ff[5];
         v_in[5] = v_ff[4];
         v_in[4] = v_ff[3] + t1;
         v_in[3] = v_ff[2];
         v_in[2] = v_ff[1];
         v_in[1] = v_ff[0];
         v_in[0] = t1 + t2;
      end
      if (ctrl.init) begin
         h_in = INIT_H;
      end else if (ctrl.fold) begin
         for (int i = 0; i < 8; i++) begin
            h_in[i] = h_ff[i] + v_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff <= INIT_H;
      end else begin
         h_ff <= h_in;
      end
   end

endmodule

// File: rtl/sha256_message_hasher.sv
// SHA-256 message hasher top level: request FSM, padding, length count, digest out.
// Flow: a byte that leaves the block short and ends no message is taken with no stall;
// the 64th byte of a block stalls requests through 64 rounds on the shared round unit
// and one fold. A last request adds pad bytes to the block end and a compression,
// another padded block and compression when the length spills, then 8 digest words.
// Reset (sync, active high) restores the initial hash; needs sha_mh_pkg, sched, core.
`include "sha256_message_hasher_assert.svh"

module sha256_message_hasher (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_valid,
   input  logic        req_last_of_message,
   // digest channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);
   import sha_mh_pkg::*;

   // one-hot sequencer
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,  // taking request bytes
      ST_COMP = 5'b00010,  // 64 rounds
      ST_FOLD = 5'b00100,  // chaining value += working variables
      ST_PAD  = 5'b01000,  // pad byte, zeros, length, one byte a cycle
      ST_EMIT = 5'b10000   // eight digest words
   } state_type;

   // where to go once a block is folded in
   typedef enum logic [1:0] {
      RET_IDLE = 2'b00,
      RET_PAD  = 2'b01,
      RET_EMIT = 2'b10
   } ret_type;

   localparam logic [5:0] FILL_FULL = 6'd63;  // last slot of the block
   localparam logic [5:0] LEN_START = 6'd56;  // first slot of the length field
   localparam logic [2:0] WORD_LAST = 3'd7;

   state_type      state_ff, state_in;
   ret_type        ret_ff, ret_in;
   logic [5:0]     fill_ff, fill_in;     // bytes held in the window
   logic [5:0]     rcnt_ff, rcnt_in;     // round counter
   logic [2:0]     idx_ff, idx_in;       // digest word being offered
   logic [63:0]    bits_ff, bits_in;     // message length in bits, wraps mod 2^64
   logic           mark_ff, mark_in;     // pad byte already placed
   logic           len_ok_ff, len_ok_in; // this block carries the length field

   logic           req_accept;
   logic           rsp_accept;
   logic [7:0]     push_byte;
   logic [7:0]     len_byte;
   logic [31:0]    w_word;
   logic           msg_clear;            // idle with no length or bytes held
   core_ctrl_type  core_ctrl;
   sched_ctrl_type sched_ctrl;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = (state_ff == ST_EMIT);
   assign rsp_accept = rsp_valid && !rsp_stall;

   assign rsp_word_index = idx_ff;
   assign rsp_last_word  = (idx_ff == WORD_LAST);

   assign msg_clear = (bits_ff == 64'd0) && (fill_ff == 6'd0) && (state_ff == ST_IDLE);

   // length bytes go out big-endian: slot 56 takes bits 63:56
   assign len_byte = bits_ff[8 * (7 - int'(fill_ff[2:0])) +: 8];

   always_comb begin
      state_in   = state_ff;
      ret_in     = ret_ff;
      fill_in    = fill_ff;
      rcnt_in    = rcnt_ff;
      idx_in     = idx_ff;
      bits_in    = bits_ff;
      mark_in    = mark_ff;
      len_ok_in  = len_ok_ff;
      push_byte  = req_data_byte;
      sched_ctrl = '0;
      core_ctrl  = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_byte_valid) begin
                  sched_ctrl.push = 1'b1;
                  bits_in         = bits_ff + 64'd8;
                  fill_in         = fill_ff + 6'd1;
                  if (fill_ff == FILL_FULL) begin
                     // block full: compress now, pad afterwards if this was the end
                     core_ctrl.load = 1'b1;
                     state_in       = ST_COMP;
                     ret_in         = req_last_of_message ? RET_PAD : RET_IDLE;
                  end else if (req_last_of_message) begin
                     state_in = ST_PAD;
                  end
               end else if (req_last_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end

         ST_PAD: begin
            sched_ctrl.push = 1'b1;
            fill_in         = fill_ff + 6'd1;
            if (!mark_ff) begin
               push_byte = PAD_BYTE;
               mark_in   = 1'b1;
               // length fits only if the pad byte lands before the length field
               if (fill_ff < LEN_START) begin
                  len_ok_in = 1'b1;
               end
            end else if (len_ok_ff && fill_ff >= LEN_START) begin
               push_byte = len_byte;
            end else begin
               push_byte = 8'h00;
            end
            if (fill_ff == FILL_FULL) begin
               core_ctrl.load = 1'b1;
               state_in       = ST_COMP;
               ret_in         = len_ok_ff ? RET_EMIT : RET_PAD;
            end
         end

         ST_COMP: begin
            core_ctrl.round = 1'b1;
            sched_ctrl.step = 1'b1;
            rcnt_in         = rcnt_ff + 6'd1;
            if (rcnt_ff == FILL_FULL) begin
               state_in = ST_FOLD;
            end
         end

         ST_FOLD: begin
            core_ctrl.fold = 1'b1;
            case (ret_ff)
               RET_PAD: begin
                  // next block: pad byte if not yet placed, zeros, then the length
                  len_ok_in = 1'b1;
                  state_in  = ST_PAD;
               end
               RET_EMIT: begin
                  idx_in   = '0;
                  state_in = ST_EMIT;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end

         ST_EMIT: begin
            if (rsp_accept) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == WORD_LAST) begin
                  core_ctrl.init = 1'b1;
                  bits_in        = '0;
                  fill_in        = '0;
                  mark_in        = 1'b0;
                  len_ok_in      = 1'b0;
                  state_in       = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ret_ff    <= RET_IDLE;
         fill_ff   <= '0;
         rcnt_ff   <= '0;
         idx_ff    <= '0;
         bits_ff   <= '0;
         mark_ff   <= 1'b0;
         len_ok_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ret_ff    <= ret_in;
         fill_ff   <= fill_in;
         rcnt_ff   <= rcnt_in;
         idx_ff    <= idx_in;
         bits_ff   <= bits_in;
         mark_ff   <= mark_in;
         len_ok_ff <= len_ok_in;
      end
   end

   sha_mh_sched u_sched (
      .clock     (clock),
      .ctrl      (sched_ctrl),
      .push_byte (push_byte),
      .w_word    (w_word)
   );

   sha_mh_core u_core (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (core_ctrl),
      .k_word   (ROUND_K[rcnt_ff]),
      .w_word   (w_word),
      .rd_index (idx_ff),
      .rd_word  (rsp_digest_word)
   );

   // no request taken while the digest is on offer
   `SHA_ASSERT_NOW(a_emit_blocks_req, clock, reset, rsp_valid, req_stall)
   // round counter only moves inside the compression run
   `SHA_ASSERT_NOW(a_rcnt_in_comp, clock, reset, rcnt_ff != 6'd0, state_ff == ST_COMP)
   // after the final word the length and fill start again from zero
   `SHA_ASSERT_NEXT(a_clear_after_digest, clock, reset, rsp_accept && rsp_last_word, msg_clear)

endmodule
